// ===== hdl/ssrm_pkg.sv =====
// Shared types and constants for the sensor sample-rate meter.
// No dependencies; imported by sensor_sample_rate_meter_core.
package ssrm_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned FIFO_CNT_W = 5;

  localparam logic [COUNT_W-1:0] FIFO_DEPTH   = 6'd32;
  localparam logic [DATA_W-1:0]  WINDOW_RESET = 32'd10000;

  localparam int unsigned        OVR_BIT      = 6;

  localparam int unsigned        SCALE_W      = 21;
  localparam logic [SCALE_W-1:0] MHZ_SCALE    = 21'd1000000;

  localparam int unsigned        DQ_W         = 2 * DATA_W;
  localparam int unsigned        STEP_W       = 6;
  localparam logic [STEP_W-1:0]  MUL_LAST     = 6'(DATA_W - 1);
  localparam logic [STEP_W-1:0]  DIV_LAST     = 6'(DQ_W - 1);

  localparam logic REQ_MODE  = 1'b0;
  localparam logic REQ_BATCH = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_MODE = 1'b1;

  typedef enum logic [1:0] {
    MODE_OFF       = 2'd0,
    MODE_LOW_POWER = 2'd1,
    MODE_ACTIVE    = 2'd2,
    MODE_INVALID   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_ADD,
    ST_CMP,
    ST_MUL,
    ST_DIV,
    ST_PUB,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/sensor_sample_rate_meter_core.sv =====
// Sample-rate meter top level: mode tracking, batch accounting and a
// bit-serial multiply / restoring divide for the published rate.
// Depends on ssrm_pkg.
//
// channel  direction  handshake            payload
// in       to core    in_valid / in_stall  req_type, new_mode, fifo_status, now_ms
// out      from core  out_valid / out_stall status, sample_count, overrun,
//                                          rate_mhz, rate_updated, mode_now
// cfg      to core    cfg_valid / cfg_ready window_ms
//
// One transaction at a time. A mode event or a batch that closes no window
// goes from ST_EVAL (a counted batch in active mode via ST_ADD and ST_CMP) to
// ST_DONE; a batch that closes a window runs the 32-step shift-add multiplier
// and the 64-step restoring divider, sharing one 64-bit shift register, first.
// Reset is synchronous: all sums and the rate clear, window returns to 10000.
// A held result in the output register does not block the next acceptance.
module sensor_sample_rate_meter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [1:0]                    new_mode,
  input  logic [7:0]                    fifo_status,
  input  logic [ssrm_pkg::DATA_W-1:0]   now_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          status,
  output logic [ssrm_pkg::COUNT_W-1:0]  sample_count,
  output logic                          overrun,
  output logic [ssrm_pkg::DATA_W-1:0]   rate_mhz,
  output logic                          rate_updated,
  output logic [1:0]                    mode_now,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ssrm_pkg::DATA_W-1:0]   window_ms
);
  import ssrm_pkg::*;

  state_t              state, state_next;
  logic                out_load;

  logic [DATA_W-1:0]   window_len;
  logic [1:0]          current_mode;
  logic [DATA_W-1:0]   sample_total;
  logic [DATA_W-1:0]   active_time;
  logic [DATA_W-1:0]   last_stamp;
  logic [DATA_W-1:0]   published_rate;

  logic                op_req;
  logic [1:0]          op_mode;
  logic [7:0]          op_src;
  logic [DATA_W-1:0]   op_now;
  logic [DATA_W-1:0]   elapsed;

  logic                res_status;
  logic [COUNT_W-1:0]  res_count;
  logic                res_ovr;
  logic                res_updated;

  logic [STEP_W-1:0]   step;
  logic [DQ_W-1:0]     dq;
  logic [DATA_W-1:0]   rem;

  logic                src_ovr;
  logic [COUNT_W-1:0]  src_cnt;
  logic [COUNT_W-1:0]  cnt_dec;
  logic                batch_hit;
  logic [DATA_W:0]     sat_sum;
  logic [DATA_W-1:0]   win_eff;
  logic                window_hit;
  logic [SCALE_W-1:0]  mul_sum;
  logic [DATA_W:0]     div_trial;
  logic                div_ge;
  logic [DATA_W:0]     div_diff;

  assign cfg_ready = 1'b1;

  // count decode and accumulation terms
  always_comb begin
    src_ovr   = op_src[OVR_BIT];
    src_cnt   = {1'b0, op_src[FIFO_CNT_W-1:0]};
    if (src_ovr || (src_cnt > FIFO_DEPTH)) begin
      cnt_dec = FIFO_DEPTH;
    end else begin
      cnt_dec = src_cnt;
    end
    batch_hit  = (op_req == REQ_BATCH) && (cnt_dec != '0) &&
                 (current_mode == MODE_ACTIVE);
    sat_sum    = {1'b0, sample_total} + {{(DATA_W+1-COUNT_W){1'b0}}, cnt_dec};
    win_eff    = (window_len == '0) ? {{(DATA_W-1){1'b0}}, 1'b1} : window_len;
    window_hit = (active_time >= win_eff);
  end

  // serial multiply and divide steps
  always_comb begin
    mul_sum   = dq[DATA_W +: SCALE_W] + (dq[0] ? MHZ_SCALE : '0);
    div_trial = {rem, dq[DQ_W-1]};
    div_ge    = (div_trial >= {1'b0, active_time});
    div_diff  = div_trial - {1'b0, active_time};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = batch_hit ? ST_ADD : ST_DONE;
      end
      ST_ADD: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = window_hit ? ST_MUL : ST_DONE;
      end
      ST_MUL: begin
        if (step == MUL_LAST) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (step == DIV_LAST) state_next = ST_PUB;
      end
      ST_PUB: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    out_load = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_len <= window_ms;
    end
  end

  // accept
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_req  <= req_type;
      op_mode <= new_mode;
      op_src  <= fifo_status;
      op_now  <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode   <= MODE_OFF;
      sample_total   <= '0;
      active_time    <= '0;
      last_stamp     <= '0;
      published_rate <= '0;
    end else begin
      unique case (state)
        ST_EVAL: begin
          if (op_req == REQ_MODE) begin
            if (op_mode != MODE_INVALID && op_mode != current_mode) begin
              current_mode <= op_mode;
              if (op_mode == MODE_ACTIVE) last_stamp <= op_now;
            end
          end else if (batch_hit) begin
            sample_total <= sat_sum[DATA_W] ? '1 : sat_sum[DATA_W-1:0];
            last_stamp   <= op_now;
          end
        end
        ST_ADD: begin
          active_time <= active_time + elapsed;
        end
        ST_CMP: begin
          if (window_hit) sample_total <= '0;
        end
        ST_PUB: begin
          published_rate <= (dq[DQ_W-1:DATA_W] != '0) ? '1 : dq[DATA_W-1:0];
          active_time    <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_EVAL: begin
        elapsed     <= op_now - last_stamp;
        res_updated <= 1'b0;
        if (op_req == REQ_MODE) begin
          res_status <= (op_mode == MODE_INVALID) ? STATUS_BAD_MODE : STATUS_OK;
          res_count  <= '0;
          res_ovr    <= 1'b0;
        end else begin
          res_status <= STATUS_OK;
          res_count  <= cnt_dec;
          res_ovr    <= src_ovr;
        end
      end
      ST_CMP: begin
        dq   <= {{(DQ_W-DATA_W){1'b0}}, sample_total};
        step <= '0;
      end
      ST_MUL: begin
        dq   <= {{(DQ_W-DATA_W-SCALE_W+1){1'b0}}, mul_sum, dq[DATA_W-1:1]};
        rem  <= '0;
        step <= (step == MUL_LAST) ? '0 : step + 1'b1;
      end
      ST_DIV: begin
        dq   <= {dq[DQ_W-2:0], div_ge};
        rem  <= div_ge ? div_diff[DATA_W-1:0] : div_trial[DATA_W-1:0];
        step <= step + 1'b1;
      end
      ST_PUB: begin
        res_updated <= 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= res_status;
      sample_count <= res_count;
      overrun      <= res_ovr;
      rate_mhz     <= published_rate;
      rate_updated <= res_updated;
      mode_now     <= current_mode;
    end
  end

  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction accepted while one is in flight");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < active_time))
    else $error("divider remainder not below divisor");

  a_bad_mode_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_BAD_MODE) |-> (sample_count == '0 && !rate_updated))
    else $error("invalid mode result carries batch data");

  a_update_needs_samples: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rate_updated) |-> (sample_count != '0 && mode_now == MODE_ACTIVE))
    else $error("rate published without an active batch");

endmodule
